FILE: design/psls_pkg.sv
// Package with the types, constants and codes shared by the segment length statistics block.
package psls_pkg;

  localparam int MAX_NODES  = 64;
  localparam int COORD_BITS = 24;

  localparam int LEN_W     = 26;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = $clog2(MAX_NODES);
  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int SQ_W      = 2 * ROOT_BITS;
  localparam int REM_W     = ROOT_BITS + 3;
  localparam int EXT_W     = (ROOT_BITS > LEN_W) ? ROOT_BITS : LEN_W;
  localparam int ITER_MAX  = (ROOT_BITS > SUM_W) ? ROOT_BITS : SUM_W;
  localparam int ITER_W    = $clog2(ITER_MAX);

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LEN_W;

  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_LENGTH = 1'b1;

  localparam logic [1:0] MODE_ACTUAL  = 2'd0;
  localparam logic [1:0] MODE_AVERAGE = 2'd1;
  localparam logic [1:0] MODE_FIXED   = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_SEG = 2'd1;
  localparam logic [1:0] STATUS_LIMIT  = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
    logic                         final_point;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] nominal_length;
    logic [LEN_W-1:0] min_length;
    logic [LEN_W-1:0] max_length;
    logic [LEN_W-1:0] mean_length;
    logic [1:0]       status;
    logic             run_end;
  } out_word_t;

  typedef enum logic [1:0] {
    EMIT_SEG,
    EMIT_LONE,
    EMIT_FINAL,
    EMIT_RUN
  } emit_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQUARE,
    ST_ROOT,
    ST_UPDATE,
    ST_POST,
    ST_DIVIDE,
    ST_EMIT_SEG,
    ST_EMIT_LONE,
    ST_EMIT_FINAL,
    ST_EMIT_RUN,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       iter_clr;
    logic       sq_step;
    logic       root_step;
    logic       update;
    logic       div_load;
    logic       div_step;
    logic       emit;
    emit_kind_e kind;
    logic       clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic seg;
    logic final_pt;
    logic mode_avg;
    logic cnt_zero;
    logic sq_last;
    logic root_last;
    logic div_last;
    logic run_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/psls_ctrl.sv
// Controller state machine that sequences square, root, divide and result steps.
module psls_ctrl
  import psls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = status_i.seg ? ST_SQUARE : ST_POST;
      end
      ST_SQUARE: begin
        if (status_i.sq_last) state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_last) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_d = ST_POST;
      end
      ST_POST: begin
        if (!status_i.final_pt) begin
          state_d = (status_i.seg && !status_i.mode_avg) ? ST_EMIT_SEG : ST_IDLE;
        end else if (status_i.cnt_zero) begin
          state_d = ST_EMIT_LONE;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) state_d = status_i.mode_avg ? ST_EMIT_RUN : ST_EMIT_FINAL;
      end
      ST_EMIT_SEG: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_EMIT_LONE, ST_EMIT_FINAL: begin
        if (status_i.out_free) state_d = ST_CLEAR;
      end
      ST_EMIT_RUN: begin
        if (status_i.out_free && status_i.run_last) state_d = ST_CLEAR;
      end
      ST_CLEAR: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = EMIT_SEG;
    cmd_o.iter_clr = 1'b1;
    in_stall_o     = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      ST_SQUARE: begin
        cmd_o.sq_step  = 1'b1;
        cmd_o.iter_clr = status_i.sq_last;
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        cmd_o.iter_clr  = 1'b0;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      ST_POST: begin
        cmd_o.div_load = 1'b1;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cmd_o.iter_clr = 1'b0;
      end
      ST_EMIT_SEG: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = EMIT_SEG;
      end
      ST_EMIT_LONE: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = EMIT_LONE;
      end
      ST_EMIT_FINAL: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = EMIT_FINAL;
      end
      ST_EMIT_RUN: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = EMIT_RUN;
      end
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      default: begin
        cmd_o.iter_clr = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/psls_datapath.sv
// Datapath with chain state, squarer, bitwise square root, divider and output register.
module psls_datapath
  import psls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_word_t              in_word_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o
);

  logic [1:0]       mode_q;
  logic [LEN_W-1:0] user_q;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, prev_z_q;
  logic                         have_prev_q;
  logic [CNT_W-1:0]             count_q;
  logic [LEN_W-1:0]             min_q, max_q, len_q;
  logic [SUM_W-1:0]             sum_q;
  logic                         ovf_q;
  in_word_t                     item_q;
  logic                         seg_q;

  logic [COORD_BITS:0] mag_x_q, mag_y_q, mag_z_q;
  logic [ITER_W-1:0]   iter_q;
  logic [SQ_W-1:0]     rad_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [SUM_W-1:0]    quo_q;
  logic [CNT_W-1:0]    drem_q;
  logic [CNT_W-1:0]    run_q;

  logic                out_valid_q;
  out_word_t           out_q;

  logic                  at_limit;
  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [COORD_BITS:0]   mag_sel;
  logic [SQ_W-1:0]       sq;
  logic [REM_W-1:0]      rem_shift, root_trial;
  logic                  root_ge;
  logic [EXT_W-1:0]      root_ext;
  logic [LEN_W-1:0]      len_new;
  logic [CNT_W:0]        div_t;
  logic                  div_ge;
  logic [LEN_W-1:0]      mean;
  logic [LEN_W-1:0]      seg_nom;
  logic [1:0]            fin_status;
  logic                  out_free, out_load;
  out_word_t             out_d;

  function automatic logic [COORD_BITS:0] abs_diff(logic signed [COORD_BITS:0] d);
    abs_diff = d[COORD_BITS] ? (COORD_BITS+1)'(-d) : (COORD_BITS+1)'(d);
  endfunction

  assign at_limit = have_prev_q && (count_q == CNT_W'(MAX_NODES - 1));
  assign dx = {in_word_i.x_coord[COORD_BITS-1], in_word_i.x_coord}
            - {prev_x_q[COORD_BITS-1], prev_x_q};
  assign dy = {in_word_i.y_coord[COORD_BITS-1], in_word_i.y_coord}
            - {prev_y_q[COORD_BITS-1], prev_y_q};
  assign dz = {in_word_i.z_coord[COORD_BITS-1], in_word_i.z_coord}
            - {prev_z_q[COORD_BITS-1], prev_z_q};

  always_comb begin
    case (iter_q[1:0])
      2'd0:    mag_sel = mag_x_q;
      2'd1:    mag_sel = mag_y_q;
      default: mag_sel = mag_z_q;
    endcase
  end

  assign sq = SQ_W'(mag_sel) * SQ_W'(mag_sel);

  assign rem_shift  = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign root_trial = {(REM_W-2)'(root_q), 2'b01};
  assign root_ge    = (rem_shift >= root_trial);

  assign root_ext = EXT_W'(root_q);
  assign len_new  = (root_ext > EXT_W'(LEN_MAX)) ? LEN_MAX : root_ext[LEN_W-1:0];

  assign div_t  = {drem_q, quo_q[SUM_W-1]};
  assign div_ge = (div_t >= {1'b0, count_q});
  assign mean   = quo_q[LEN_W-1:0];

  assign seg_nom    = (mode_q == MODE_ACTUAL) ? len_q : user_q;
  assign fin_status = ovf_q ? STATUS_LIMIT : STATUS_OK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ACTUAL;
      user_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LENGTH_MODE: mode_q <= cfg_data_i[1:0];
        REG_USER_LENGTH: user_q <= cfg_data_i[LEN_W-1:0];
        default:         mode_q <= mode_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      count_q     <= '0;
      min_q       <= LEN_MAX;
      max_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      seg_q       <= 1'b0;
      iter_q      <= '0;
      run_q       <= '0;
    end else begin
      if (cmd_i.iter_clr) begin
        iter_q <= '0;
      end else if (cmd_i.sq_step || cmd_i.root_step || cmd_i.div_step) begin
        iter_q <= iter_q + ITER_W'(1);
      end
      if (cmd_i.accept) begin
        seg_q <= have_prev_q && !at_limit;
        if (at_limit) ovf_q <= 1'b1;
        if (!have_prev_q) have_prev_q <= 1'b1;
      end
      if (cmd_i.update) begin
        sum_q   <= sum_q + SUM_W'(len_new);
        count_q <= count_q + CNT_W'(1);
        if (len_new < min_q) min_q <= len_new;
        if (len_new > max_q) max_q <= len_new;
      end
      if (cmd_i.div_load) begin
        run_q <= '0;
      end else if (out_load && cmd_i.kind == EMIT_RUN) begin
        run_q <= run_q + CNT_W'(1);
      end
      if (cmd_i.clear) begin
        have_prev_q <= 1'b0;
        count_q     <= '0;
        min_q       <= LEN_MAX;
        max_q       <= '0;
        sum_q       <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q  <= in_word_i;
      mag_x_q <= abs_diff(dx);
      mag_y_q <= abs_diff(dy);
      mag_z_q <= abs_diff(dz);
      if (!have_prev_q) begin
        prev_x_q <= in_word_i.x_coord;
        prev_y_q <= in_word_i.y_coord;
        prev_z_q <= in_word_i.z_coord;
      end
    end
    if (cmd_i.sq_step) begin
      rad_q  <= (iter_q == '0) ? sq : rad_q + sq;
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= root_ge ? rem_shift - root_trial : rem_shift;
      root_q <= {root_q[ROOT_BITS-2:0], root_ge};
    end
    if (cmd_i.update) begin
      len_q    <= len_new;
      prev_x_q <= item_q.x_coord;
      prev_y_q <= item_q.y_coord;
      prev_z_q <= item_q.z_coord;
    end
    if (cmd_i.clear) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      prev_z_q <= '0;
    end
    if (cmd_i.div_load) begin
      quo_q  <= sum_q;
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q  <= {quo_q[SUM_W-2:0], div_ge};
      drem_q <= div_ge ? CNT_W'(div_t - {1'b0, count_q}) : div_t[CNT_W-1:0];
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_d = '0;
    case (cmd_i.kind)
      EMIT_SEG: begin
        out_d.nominal_length = seg_nom;
        out_d.min_length     = min_q;
        out_d.max_length     = max_q;
      end
      EMIT_LONE: begin
        out_d.status  = STATUS_NO_SEG;
        out_d.run_end = 1'b1;
      end
      EMIT_FINAL: begin
        out_d.nominal_length = seg_q ? seg_nom : '0;
        out_d.min_length     = min_q;
        out_d.max_length     = max_q;
        out_d.mean_length    = mean;
        out_d.status         = fin_status;
        out_d.run_end        = 1'b1;
      end
      EMIT_RUN: begin
        out_d.nominal_length = mean;
        out_d.min_length     = min_q;
        out_d.max_length     = max_q;
        if (status_o.run_last) begin
          out_d.mean_length = mean;
          out_d.status      = fin_status;
          out_d.run_end     = 1'b1;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.emit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    status_o           = '0;
    status_o.seg       = seg_q;
    status_o.final_pt  = item_q.final_point;
    status_o.mode_avg  = (mode_q == MODE_AVERAGE);
    status_o.cnt_zero  = (count_q == '0);
    status_o.sq_last   = (iter_q == ITER_W'(2));
    status_o.root_last = (iter_q == ITER_W'(ROOT_BITS - 1));
    status_o.div_last  = (iter_q == ITER_W'(SUM_W - 1));
    status_o.run_last  = (({1'b0, run_q} + (CNT_W+1)'(1)) == {1'b0, count_q});
    status_o.out_free  = out_free;
  end

endmodule

FILE: design/polyline_segment_length_stats_unit.sv
// Top level of the polyline segment length statistics block.
// Points enter one word at a time and are taken only while the block is idle. A point that
// closes a segment holds the input from its accepting cycle to the next one: it is accepted,
// checked, squared axis by axis on the shared squarer and passed to the square root unit,
// which settles one result bit per cycle; then the statistics are updated, the divider is
// preset and the output register is loaded. In average mode such a point loads no word. A
// final point also runs the one-bit-per-cycle divider for the mean, then clears the chain,
// and in average mode loads one word of the mean run per cycle while the output is not held.
// A point that is not final and forms no segment is accepted, checked and passed through the
// post step; a lone final point then also loads one word and clears the chain. A waiting word
// that holds the output register stalls the step that loads the next word.
module polyline_segment_length_stats_unit
  import psls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  psls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  psls_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a word and did not go busy");

  a_emit_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> in_stall_o)
    else $error("result issued while input side was open");

  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != STATUS_OK) |-> out_word_o.run_end)
    else $error("status set on a result that does not end the chain");

  a_mean_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.mean_length != '0) |-> out_word_o.run_end)
    else $error("mean set on a result that does not end the chain");

endmodule
